[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold at the same edge as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ctdw_pkg.sv]
// Shared types, constants and the divide-by-ten helper for count_to_digit_writes.
// No dependencies.
package ctdw_pkg;

    localparam int DIGIT_COUNT_DEF = 8;
    localparam int MAX_DIGITS      = 8;
    localparam int COUNT_W         = 32;
    localparam int ADDR_W          = 4;
    localparam int CODE_W          = 8;
    localparam int DIGIT_W         = 4;
    localparam int POS_W           = 3;
    localparam int QUOT_W          = 29;   // floor((2^32-1)/10) fits 29 bits
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'b1111;
    localparam logic [POS_W-1:0]   SEP_POS_A  = 3'd3;
    localparam logic [POS_W-1:0]   SEP_POS_B  = 3'd6;

    // reciprocal of ten, scaled by 2^35; exact over the full 32-bit range
    localparam logic [COUNT_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [QUOT_W-1:0]  rest;
    } entry_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [QUOT_W-1:0]  quot;
    } divmod_t;

    function automatic divmod_t div_ten(input logic [COUNT_W-1:0] x);
        logic [2*COUNT_W-1:0] prod;
        logic [QUOT_W-1:0]    q;
        logic [COUNT_W-1:0]   q_times_ten;
        logic [COUNT_W-1:0]   r;
        divmod_t              res;
        prod        = {{COUNT_W{1'b0}}, x} * {{COUNT_W{1'b0}}, RECIP_TEN};
        q           = prod[2*COUNT_W-1:RECIP_SHIFT];
        q_times_ten = ({3'b000, q} << 3) + ({3'b000, q} << 1);
        r           = x - q_times_ten;
        res.digit   = r[DIGIT_W-1:0];
        res.quot    = q;
        return res;
    endfunction

endpackage

[rtl/count_to_digit_writes.sv]
// count_to_digit_writes: each 32-bit count becomes DIGIT_COUNT (held to 1..MAX_DIGITS)
// digit-register writes, lowest digit first at address 1, with separator points and
// leading-zero blanking. One write leaves per cycle while out_ready is high, and counts
// follow back to back; the output channel sets the pace. The first write of a count passes
// through the input register with its divide-by-ten multiplier, a two-entry queue, then the
// digit sequencer's output register. Depends on ctdw_pkg.
module count_to_digit_writes #(
    parameter int DIGIT_COUNT = ctdw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ctdw_pkg::COUNT_W-1:0] count_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ctdw_pkg::ADDR_W-1:0]  digit_address,
    output logic [ctdw_pkg::CODE_W-1:0]  digit_code,
    output logic                         last_digit
);
    import ctdw_pkg::*;

    logic   push_valid, push_ready;
    entry_t push_data;
    logic   pop_valid, pop_ready;
    entry_t pop_data;

    ctdw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .count_value (count_value),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    ctdw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ctdw_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digit_address (digit_address),
        .digit_code    (digit_code),
        .last_digit    (last_digit)
    );

endmodule

[rtl/ctdw_front.sv]
// Front end: takes counts, splits off the lowest decimal digit and pushes it to the queue.
// Depends on ctdw_pkg.
module ctdw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ctdw_pkg::COUNT_W-1:0]  count_value,
    output logic                          push_valid,
    input  logic                          push_ready,
    output ctdw_pkg::entry_t              push_data
);
    import ctdw_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [COUNT_W-1:0] count_reg;
    divmod_t            dm;

    assign in_ready = !valid_reg || push_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            count_reg <= count_value;
        end
    end

    assign dm              = div_ten(count_reg);
    assign push_valid      = valid_reg;
    assign push_data.digit = dm.digit;
    assign push_data.rest  = dm.quot;

endmodule

[rtl/ctdw_queue.sv]
// Short FIFO between front and back end, register storage.
// Depends on ctdw_pkg.
module ctdw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  ctdw_pkg::entry_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ctdw_pkg::entry_t  pop_data
);
    import ctdw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/ctdw_back.sv]
// Back end: steps an item's digits into an output register, one write per cycle unless stalled.
// Depends on ctdw_pkg.
module ctdw_back #(
    parameter int DIGIT_COUNT = ctdw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  ctdw_pkg::entry_t             pop_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ctdw_pkg::ADDR_W-1:0]  digit_address,
    output logic [ctdw_pkg::CODE_W-1:0]  digit_code,
    output logic                         last_digit
);
    import ctdw_pkg::*;

    // writes per item, held to 1..MAX_DIGITS
    localparam int RUN_LEN = (DIGIT_COUNT < 1) ? 1 :
                             (DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(RUN_LEN - 1);
    localparam logic             ONE_DIGIT = (RUN_LEN == 1);

    logic               busy_reg, busy_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0] rest_reg, rest_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               last_reg, last_next;
    logic               advance;
    logic               sep;
    logic               blank;
    divmod_t            dm;

    assign advance   = !out_valid_reg || out_ready;
    assign pop_ready = advance && !busy_reg;
    assign dm        = div_ten(rest_reg);
    // remaining value zero means this digit and all above it are zero
    assign blank     = (rest_reg == '0);

    always_comb
    begin
        case (pos_reg) inside
            SEP_POS_A, SEP_POS_B: sep = 1'b1;
            default:              sep = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        rest_next      = rest_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = 1'b0;
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                addr_next      = ADDR_W'(pos_reg) + 1'b1;
                last_next      = (pos_reg == LAST_POS);
                if (blank)
                begin
                    code_next = {{(CODE_W-DIGIT_W){1'b0}}, BLANK_CODE};
                end
                else
                begin
                    code_next = {sep, {(CODE_W-DIGIT_W-1){1'b0}}, dm.digit};
                end
                rest_next = {{(COUNT_W-QUOT_W){1'b0}}, dm.quot};
                pos_next  = pos_reg + 1'b1;
                busy_next = (pos_reg != LAST_POS);
            end
            else if (pop_valid)
            begin
                // lowest digit is never blanked and never carries a point
                out_valid_next = 1'b1;
                addr_next      = ADDR_W'(1);
                last_next      = ONE_DIGIT;
                code_next      = {{(CODE_W-DIGIT_W){1'b0}}, pop_data.digit};
                rest_next      = {{(COUNT_W-QUOT_W){1'b0}}, pop_data.rest};
                pos_next       = POS_W'(1);
                busy_next      = !ONE_DIGIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        addr_reg <= addr_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign digit_address = addr_reg;
    assign digit_code    = code_reg;
    assign last_digit    = last_reg;

endmodule

[rtl/ctdw_checker.sv]
// Port-level checks for count_to_digit_writes, bound to the top level.
// Depends on ctdw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctdw_checker #(
    parameter int DIGIT_COUNT = ctdw_pkg::DIGIT_COUNT_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [ctdw_pkg::COUNT_W-1:0] count_value,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ctdw_pkg::ADDR_W-1:0]  digit_address,
    input logic [ctdw_pkg::CODE_W-1:0]  digit_code,
    input logic                         last_digit
);
    import ctdw_pkg::*;

    localparam int RUN_LEN = (DIGIT_COUNT < 1) ? 1 :
                             (DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RUN_LEN);

    logic out_take;
    logic in_take;
    assign out_take = out_valid && out_ready;
    assign in_take  = in_valid && in_ready && (count_value == count_value);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(digit_address) && $stable(digit_code) && $stable(last_digit),
        "stalled write changed")
    `ASSERT_IMPL(a_last_addr, out_valid, last_digit == (digit_address == LAST_ADDR),
        "last flag disagrees with address")
    `ASSERT_IMPL(a_code_bits, out_valid, digit_code[6:4] == 3'b000,
        "unused code bits set")
    `ASSERT_NEXT(a_addr_step, out_take && !last_digit,
        !out_valid || (digit_address == $past(digit_address) + 1'b1),
        "digit address did not step")
    `ASSERT_IMPL(a_first_addr, out_valid && (digit_address == ADDR_W'(1)) && !in_take,
        digit_code[7] == 1'b0 && digit_code[3:0] != BLANK_CODE,
        "lowest digit blanked or pointed")

endmodule

bind count_to_digit_writes ctdw_checker #(.DIGIT_COUNT(DIGIT_COUNT)) u_ctdw_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench for count_to_digit_writes: directed then random counts, each of the eight digit
// writes checked against a table or an in-bench predictor. Depends on ctdw_pkg and the RTL.
module testbench;
    import ctdw_pkg::*;

    localparam int RUN_LEN        = (DIGIT_COUNT_DEF < 1) ? 1 :
                                    (DIGIT_COUNT_DEF > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT_DEF;
    localparam int RADIX          = 10;
    localparam int SEP_SPACING    = 3;
    localparam int SEP_BIT        = 7;
    localparam int IDLE_PCT       = 7;
    localparam int RANDOM_ITEMS   = 206;
    localparam int CALM_FROM      = 140;
    localparam int CALM_TO        = 190;
    localparam int HOLDOFF_AT     = 80;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int STALL_LIMIT    = 2000;
    localparam int N_DIRECTED     = 24;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] code;
        logic              last;
    } digit_write_t;

    // codes: byte n is the code written to address n+1
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               typed;
        logic [63:0]        codes;
    } stim_row_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{32'd0,          1'b1, 64'h0F0F_0F0F_0F0F_0F00},
        '{32'hFFFF_FFFF,  1'b1, 64'h0984_0906_8702_0905},
        '{32'd99999999,   1'b1, 64'h0989_0909_8909_0909},
        '{32'd100000000,  1'b1, 64'h0080_0000_8000_0000},
        '{32'd1,          1'b0, 64'h0},
        '{32'd9,          1'b0, 64'h0},
        '{32'd10,         1'b0, 64'h0},
        '{32'd99,         1'b0, 64'h0},
        '{32'd100,        1'b0, 64'h0},
        '{32'd999,        1'b0, 64'h0},
        '{32'd1000,       1'b0, 64'h0},
        '{32'd1001,       1'b0, 64'h0},
        '{32'd9999,       1'b0, 64'h0},
        '{32'd10000,      1'b0, 64'h0},
        '{32'd999999,     1'b0, 64'h0},
        '{32'd1000000,    1'b0, 64'h0},
        '{32'd1234567,    1'b0, 64'h0},
        '{32'd10000000,   1'b0, 64'h0},
        '{32'd12345678,   1'b0, 64'h0},
        '{32'd100000001,  1'b0, 64'h0},
        '{32'd1000000000, 1'b0, 64'h0},
        '{32'h8000_0000,  1'b0, 64'h0},
        '{32'h5555_5555,  1'b0, 64'h0},
        '{32'hAAAA_AAAA,  1'b0, 64'h0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [COUNT_W-1:0] count_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ADDR_W-1:0]  digit_address;
    logic [CODE_W-1:0]  digit_code;
    logic               last_digit;

    digit_write_t pending_writes [$];
    int           counts_taken = 0;
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           stall_left = 0;
    bit           holdoff_done = 1'b0;
    logic         calm;

    assign calm = (counts_taken >= CALM_FROM) && (counts_taken < CALM_TO);

    count_to_digit_writes dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .count_value   (count_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .digit_address (digit_address),
        .digit_code    (digit_code),
        .last_digit    (last_digit)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // digits of the count, lowest first; blank leading zeros of the full 32-bit value
    function automatic void predict_digit_writes(input logic [COUNT_W-1:0] value);
        logic [COUNT_W-1:0] rest;
        logic [DIGIT_W-1:0] digit;
        logic               sep;
        digit_write_t       w;
        rest = value;
        for (int pos = 0; pos < RUN_LEN; pos++)
        begin
            digit = DIGIT_W'(rest % RADIX);
            rest  = rest / RADIX;
            sep   = (pos > 0) && (pos % SEP_SPACING == 0);
            w.addr = ADDR_W'(pos + 1);
            w.last = (pos + 1 == RUN_LEN);
            w.code = '0;
            if (digit == 0 && rest == 0 && pos > 0)
                w.code[DIGIT_W-1:0] = BLANK_CODE;
            else
            begin
                w.code[DIGIT_W-1:0] = digit;
                w.code[SEP_BIT]     = sep;
            end
            pending_writes.push_back(w);
        end
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        logic [COUNT_W-1:0] p;
        p = 1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 9);
            2: return $urandom_range(0, 99999);
            3:
            begin
                repeat ($urandom_range(0, 9)) p = p * RADIX;
                return p + $urandom_range(0, 2) - 1;
            end
            4: return $urandom_range(32'd100000000, 32'hFFFF_FFFF);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // holds valid across back-to-back items; drops it only when the sender idles
    task automatic offer_count(input logic [COUNT_W-1:0] value, input logic typed,
                               input logic [63:0] codes);
        digit_write_t w;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        count_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        counts_taken++;
        if (typed)
        begin
            for (int pos = 0; pos < RUN_LEN; pos++)
            begin
                w.addr = ADDR_W'(pos + 1);
                w.code = codes[pos*8 +: 8];
                w.last = (pos + 1 == RUN_LEN);
                pending_writes.push_back(w);
            end
        end
        else
            predict_digit_writes(value);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED[i])
            offer_count(DIRECTED[i].count, DIRECTED[i].typed, DIRECTED[i].codes);
        repeat (RANDOM_ITEMS)
            offer_count(pick_count(), 1'b0, 64'h0);
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // receiver: random idling, a calm stretch, and one long hold-off to back the block up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!holdoff_done && counts_taken >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                stall_left   = HOLDOFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_writes
        digit_write_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("digit write with none expected: address %0d code %0h",
                       digit_address, digit_code);
                mismatch_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (digit_address !== want.addr)
                begin
                    $error("digit_address: expected %0d, actual %0d", want.addr, digit_address);
                    mismatch_count++;
                end
                if (digit_code !== want.code)
                begin
                    $error("digit_code: expected %02h, actual %02h", want.code, digit_code);
                    mismatch_count++;
                end
                if (last_digit !== want.last)
                begin
                    $error("last_digit: expected %0b, actual %0b", want.last, last_digit);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
